// ===== sv/thi_pkg.sv =====
// thi_pkg: shared widths, status codes and item types for the triangle height block.
// Used by every module of triangle_height_interpolate; depends on nothing.
`timescale 1ns / 1ps

package thi_pkg;

  localparam int CoordWidth = 32;
  localparam int DiffW      = CoordWidth + 1;        // corner differences
  localparam int ProdW      = 2 * DiffW;             // cross-product terms
  localparam int CrossW     = ProdW + 1;             // d, nu, nv
  localparam int MagW       = ProdW;                 // |d|, nu, nv once inside
  localparam int HalfW      = DiffW;                 // split point of nu/nv
  localparam int PartW      = 2 * DiffW;             // one partial product
  localparam int TermW      = MagW + DiffW;          // nu * |uz|
  localparam int NumW       = TermW + 1;             // |nu*uz + nv*vz|
  localparam int QuotW      = CoordWidth + 2;        // quotient bits
  localparam int SumW       = CoordWidth + 3;        // az + quotient
  localparam int QueueDepth = 8;
  localparam int QueueAw    = $clog2(QueueDepth);

  typedef enum logic [1:0] {
    HitInside     = 2'd0,
    HitOutside    = 2'd1,
    HitDegenerate = 2'd2
  } hit_e;

  typedef struct packed {
    logic signed [CoordWidth-1:0] corner_a_x;
    logic signed [CoordWidth-1:0] corner_a_y;
    logic signed [CoordWidth-1:0] corner_a_z;
    logic signed [CoordWidth-1:0] corner_b_x;
    logic signed [CoordWidth-1:0] corner_b_y;
    logic signed [CoordWidth-1:0] corner_b_z;
    logic signed [CoordWidth-1:0] corner_c_x;
    logic signed [CoordWidth-1:0] corner_c_y;
    logic signed [CoordWidth-1:0] corner_c_z;
    logic signed [CoordWidth-1:0] query_x;
    logic signed [CoordWidth-1:0] query_y;
    logic signed [CoordWidth-1:0] query_z;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                   hit_status;
    logic signed [CoordWidth-1:0] result_z;
  } out_item_t;

  // classified transaction handed from front to back
  typedef struct packed {
    hit_e                         status;
    logic signed [CoordWidth-1:0] az;
    logic signed [CoordWidth-1:0] qz;
    logic signed [DiffW-1:0]      uz;
    logic signed [DiffW-1:0]      vz;
    logic [MagW-1:0]              nu;
    logic [MagW-1:0]              nv;
    logic [MagW-1:0]              den;
  } entry_t;

  // one stage of the restoring divider pipeline
  typedef struct packed {
    hit_e                         status;
    logic signed [CoordWidth-1:0] az;
    logic signed [CoordWidth-1:0] qz;
    logic                         neg;
    logic [MagW-1:0]              den;
    logic [MagW-1:0]              rem;
    logic [QuotW-1:0]             numlo;
    logic [QuotW-1:0]             quo;
  } div_t;

endpackage

// ===== sv/thi_front.sv =====
// thi_front: differences, cross products and inside/outside/degenerate classification.
// Depends on thi_pkg; pushes one entry_t per accepted transaction.
`timescale 1ns / 1ps

module thi_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  thi_pkg::in_item_t item_i,
  output logic              push_o,
  output thi_pkg::entry_t   entry_o
);

  localparam int CW = thi_pkg::CoordWidth;
  localparam int DW = thi_pkg::DiffW;
  localparam int PW = thi_pkg::ProdW;
  localparam int XW = thi_pkg::CrossW;
  localparam int MW = thi_pkg::MagW;

  // stage 1: differences
  logic v1_q;
  logic signed [DW-1:0] ux_q, uy_q, uz_q, vx_q, vy_q, vz_q, px_q, py_q;
  logic signed [CW-1:0] az1_q, qz1_q;
  // stage 2: products
  logic v2_q;
  logic signed [PW-1:0] p_vxuy_q, p_vyux_q, p_pxuy_q, p_pyux_q, p_pyvx_q, p_pxvy_q;
  logic signed [DW-1:0] uz2_q, vz2_q;
  logic signed [CW-1:0] az2_q, qz2_q;
  // stage 3: d, nu, nv
  logic v3_q;
  logic signed [XW-1:0] d_q, nu_q, nv_q;
  logic signed [DW-1:0] uz3_q, vz3_q;
  logic signed [CW-1:0] az3_q, qz3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= accept_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ux_q  <= DW'(item_i.corner_b_x) - DW'(item_i.corner_a_x);
    uy_q  <= DW'(item_i.corner_b_y) - DW'(item_i.corner_a_y);
    uz_q  <= DW'(item_i.corner_b_z) - DW'(item_i.corner_a_z);
    vx_q  <= DW'(item_i.corner_c_x) - DW'(item_i.corner_a_x);
    vy_q  <= DW'(item_i.corner_c_y) - DW'(item_i.corner_a_y);
    vz_q  <= DW'(item_i.corner_c_z) - DW'(item_i.corner_a_z);
    px_q  <= DW'(item_i.query_x) - DW'(item_i.corner_a_x);
    py_q  <= DW'(item_i.query_y) - DW'(item_i.corner_a_y);
    az1_q <= item_i.corner_a_z;
    qz1_q <= item_i.query_z;

    p_vxuy_q <= vx_q * uy_q;
    p_vyux_q <= vy_q * ux_q;
    p_pxuy_q <= px_q * uy_q;
    p_pyux_q <= py_q * ux_q;
    p_pyvx_q <= py_q * vx_q;
    p_pxvy_q <= px_q * vy_q;
    uz2_q    <= uz_q;
    vz2_q    <= vz_q;
    az2_q    <= az1_q;
    qz2_q    <= qz1_q;

    d_q   <= XW'(p_vxuy_q) - XW'(p_vyux_q);
    nv_q  <= XW'(p_pxuy_q) - XW'(p_pyux_q);
    nu_q  <= XW'(p_pyvx_q) - XW'(p_pxvy_q);
    uz3_q <= uz2_q;
    vz3_q <= vz2_q;
    az3_q <= az2_q;
    qz3_q <= qz2_q;
  end

  // stage 4: fold the sign of d into nu and nv, then classify exactly
  logic                 d_neg, d_zero, in_tri;
  logic signed [XW-1:0] d_abs, nu_n, nv_n;
  logic signed [XW:0]   uv_sum;

  always_comb begin
    d_neg  = d_q[XW-1];
    d_zero = (d_q == '0);
    d_abs  = d_neg ? -d_q : d_q;
    nu_n   = d_neg ? -nu_q : nu_q;
    nv_n   = d_neg ? -nv_q : nv_q;
    uv_sum = (XW+1)'(nu_n) + (XW+1)'(nv_n);
    in_tri = !d_zero && !nu_n[XW-1] && !nv_n[XW-1] && (uv_sum <= (XW+1)'(d_abs));

    push_o      = v3_q;
    entry_o.az  = az3_q;
    entry_o.qz  = qz3_q;
    entry_o.uz  = uz3_q;
    entry_o.vz  = vz3_q;
    entry_o.nu  = in_tri ? nu_n[MW-1:0] : '0;
    entry_o.nv  = in_tri ? nv_n[MW-1:0] : '0;
    entry_o.den = in_tri ? d_abs[MW-1:0] : MW'(1);
    if (d_zero) begin
      entry_o.status = thi_pkg::HitDegenerate;
    end else if (in_tri) begin
      entry_o.status = thi_pkg::HitInside;
    end else begin
      entry_o.status = thi_pkg::HitOutside;
    end
  end

endmodule

// ===== sv/thi_queue.sv =====
// thi_queue: short FIFO of classified transactions between front and back.
// Depends on thi_pkg; the back drains one entry per cycle.
`timescale 1ns / 1ps

module thi_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  thi_pkg::entry_t entry_i,
  output logic            pop_o,
  output thi_pkg::entry_t entry_o,
  output logic            almost_full_o
);

  localparam int Depth = thi_pkg::QueueDepth;
  localparam int Aw    = thi_pkg::QueueAw;

  thi_pkg::entry_t mem_q [Depth];
  logic [Aw-1:0]   wr_ptr_q, rd_ptr_q;
  logic [Aw:0]     count_q, count_d;

  assign pop_o   = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  // leaves room for the transactions still inside the front
  assign almost_full_o = (count_q >= (Aw+1)'(Depth / 2));

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_o) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_o) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_o) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ===== sv/thi_back.sv =====
// thi_back: weighted height numerator, pipelined restoring divider and saturation.
// Depends on thi_pkg; accepts one entry per cycle and never stalls.
`timescale 1ns / 1ps

module thi_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_i,
  input  thi_pkg::entry_t    entry_i,
  output logic               valid_o,
  output thi_pkg::out_item_t out_o
);

  localparam int CW = thi_pkg::CoordWidth;
  localparam int DW = thi_pkg::DiffW;
  localparam int MW = thi_pkg::MagW;
  localparam int HW = thi_pkg::HalfW;
  localparam int RW = thi_pkg::PartW;
  localparam int TW = thi_pkg::TermW;
  localparam int NW = thi_pkg::NumW;
  localparam int QW = thi_pkg::QuotW;
  localparam int SW = thi_pkg::SumW;

  // stage b1: partial products of nu*|uz| and nv*|vz|
  logic                 v1_q, su1_q, sv1_q;
  logic [RW-1:0]        plu_q, phu_q, plv_q, phv_q;
  logic [DW-1:0]        uzm, vzm;
  thi_pkg::entry_t      e1_q, e2_q, e3_q;
  // stage b2: full magnitudes
  logic                 v2_q, su2_q, sv2_q;
  logic [TW-1:0]        tu_q, tv_q;
  // stage b3: signed numerator
  logic                 v3_q;
  logic signed [NW:0]   num_q, tus, tvs;

  assign uzm = entry_i.uz[DW-1] ? DW'(-entry_i.uz) : DW'(entry_i.uz);
  assign vzm = entry_i.vz[DW-1] ? DW'(-entry_i.vz) : DW'(entry_i.vz);
  assign tus = $signed({2'b00, tu_q});
  assign tvs = $signed({2'b00, tv_q});

  always_ff @(posedge clk_i) begin
    plu_q <= entry_i.nu[HW-1:0] * uzm;
    phu_q <= entry_i.nu[MW-1:HW] * uzm;
    plv_q <= entry_i.nv[HW-1:0] * vzm;
    phv_q <= entry_i.nv[MW-1:HW] * vzm;
    su1_q <= entry_i.uz[DW-1];
    sv1_q <= entry_i.vz[DW-1];
    e1_q  <= entry_i;

    tu_q  <= (TW'(phu_q) << HW) + TW'(plu_q);
    tv_q  <= (TW'(phv_q) << HW) + TW'(plv_q);
    su2_q <= su1_q;
    sv2_q <= sv1_q;
    e2_q  <= e1_q;

    num_q <= (su2_q ? -tus : tus) + (sv2_q ? -tvs : tvs);
    e3_q  <= e2_q;
  end

  // divider: the quotient is bounded by max(|uz|,|vz|), so QW steps suffice
  thi_pkg::div_t    dv_q [QW+1];
  logic [QW:0]      dvv_q;
  logic             n_neg;
  logic [NW-1:0]    n_mag;

  assign n_neg = num_q[NW];
  assign n_mag = n_neg ? NW'(-num_q) : NW'(num_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      dvv_q <= '0;
    end else begin
      v1_q  <= pop_i;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      dvv_q <= {dvv_q[QW-1:0], v3_q};
    end
  end

  always_ff @(posedge clk_i) begin
    dv_q[0].status <= e3_q.status;
    dv_q[0].az     <= e3_q.az;
    dv_q[0].qz     <= e3_q.qz;
    dv_q[0].neg    <= n_neg;
    dv_q[0].den    <= e3_q.den;
    dv_q[0].rem    <= n_mag[NW-1:QW];
    dv_q[0].numlo  <= n_mag[QW-1:0];
    dv_q[0].quo    <= '0;
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [MW:0] r2;
    logic        ge;
    assign r2 = {dv_q[k].rem, dv_q[k].numlo[QW-1]};
    assign ge = (r2 >= {1'b0, dv_q[k].den});
    always_ff @(posedge clk_i) begin
      dv_q[k+1].status <= dv_q[k].status;
      dv_q[k+1].az     <= dv_q[k].az;
      dv_q[k+1].qz     <= dv_q[k].qz;
      dv_q[k+1].neg    <= dv_q[k].neg;
      dv_q[k+1].den    <= dv_q[k].den;
      dv_q[k+1].rem    <= ge ? MW'(r2 - {1'b0, dv_q[k].den}) : r2[MW-1:0];
      dv_q[k+1].numlo  <= dv_q[k].numlo << 1;
      dv_q[k+1].quo    <= {dv_q[k].quo[QW-2:0], ge};
    end
  end

  // final add and clamp
  logic signed [SW-1:0] q_s, z_sum;
  logic signed [CW-1:0] z_sat;
  logic                 valid_q;
  thi_pkg::out_item_t   out_q;

  always_comb begin
    q_s   = $signed({1'b0, dv_q[QW].quo});
    z_sum = SW'(dv_q[QW].az) + (dv_q[QW].neg ? -q_s : q_s);
    if (z_sum > $signed({4'b0000, {(CW-1){1'b1}}})) begin
      z_sat = $signed({1'b0, {(CW-1){1'b1}}});
    end else if (z_sum < $signed({4'b1111, {(CW-1){1'b0}}})) begin
      z_sat = $signed({1'b1, {(CW-1){1'b0}}});
    end else begin
      z_sat = z_sum[CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= dvv_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q.hit_status <= dv_q[QW].status;
    out_q.result_z   <= (dv_q[QW].status == thi_pkg::HitInside) ? z_sat : dv_q[QW].qz;
  end

  assign valid_o = valid_q;
  assign out_o   = out_q;

endmodule

// ===== sv/triangle_height_interpolate.sv =====
// triangle_height_interpolate: top level, front classifier, queue and back divider.
// Depends on thi_pkg, thi_front, thi_queue and thi_back.
//
// One transaction (three corners and a query point, signed Q24.8) is taken per clock
// while busy is low; busy stays low in steady streaming, so a new transaction
// can enter every cycle. Each transaction gives exactly one result, in order, strobed
// by valid_o for one cycle. Results pass through three front stages, the queue,
// three multiply stages and the restoring divider, one quotient bit per pipeline stage.
// The receiver cannot hold results off; results are never dropped.
`timescale 1ns / 1ps

module triangle_height_interpolate (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  thi_pkg::in_item_t  item_i,
  output logic               valid_o,
  output thi_pkg::out_item_t result_o
);

  logic            accept;
  logic            push, pop, almost_full;
  thi_pkg::entry_t push_entry, pop_entry;

  assign busy   = almost_full;
  assign accept = start && !busy;

  thi_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item_i),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  thi_queue u_queue (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .entry_i       (push_entry),
    .pop_o         (pop),
    .entry_o       (pop_entry),
    .almost_full_o (almost_full)
  );

  thi_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pop_i   (pop),
    .entry_i (pop_entry),
    .valid_o (valid_o),
    .out_o   (result_o)
  );

endmodule

// ===== dv/tb_triangle_height_interpolate.sv =====
// Testbench for triangle_height_interpolate: directed and random triangles and queries,
// checked against a behavioral barycentric predictor. Depends on thi_pkg and the RTL.
`timescale 1ns / 1ps

module tb_triangle_height_interpolate;

  localparam int Latency  = 43;
  localparam int MaxCycle = 400000;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  thi_pkg::in_item_t   item_i;
  logic                valid_o;
  thi_pkg::out_item_t  result_o;

  triangle_height_interpolate u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .valid_o (valid_o),
    .result_o(result_o)
  );

  thi_pkg::in_item_t  pending_q[$];
  thi_pkg::out_item_t height_q[$];
  int        phase;        // 0: sender idles sometimes, 1: more often, 2: never
  int        drain_req;    // sender holds until height_q is empty
  int        n_inside, n_outside, n_degen, n_sent, n_checked;
  int        mismatches;
  int        cycles;
  bit        sent_last;    // a transaction was taken at the last rising edge

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void add_item(thi_pkg::in_item_t it);
    pending_q.insert(pending_q.size(), it);
  endfunction

  // Exact barycentric interpolation with wide signed integers.
  function automatic thi_pkg::out_item_t interp_height(thi_pkg::in_item_t it);
    logic signed [191:0] ax, ay, az, ux, uy, uz, vx, vy, vz, px, py;
    logic signed [191:0] den, nu, nv, num, quo, r, hi, lo;
    thi_pkg::out_item_t o;
    ax = it.corner_a_x; ay = it.corner_a_y; az = it.corner_a_z;
    ux = 192'(signed'(it.corner_b_x)) - ax;
    uy = 192'(signed'(it.corner_b_y)) - ay;
    uz = 192'(signed'(it.corner_b_z)) - az;
    vx = 192'(signed'(it.corner_c_x)) - ax;
    vy = 192'(signed'(it.corner_c_y)) - ay;
    vz = 192'(signed'(it.corner_c_z)) - az;
    px = 192'(signed'(it.query_x)) - ax;
    py = 192'(signed'(it.query_y)) - ay;
    den = vx * uy - vy * ux;
    nv  = px * uy - py * ux;
    nu  = py * vx - px * vy;
    o.hit_status = thi_pkg::HitOutside;
    o.result_z   = it.query_z;
    if (den == 0) begin
      o.hit_status = thi_pkg::HitDegenerate;
      return o;
    end
    if (den < 0) begin
      den = -den; nu = -nu; nv = -nv;
    end
    if (nu >= 0 && nv >= 0 && nu + nv <= den) begin
      num = nu * uz + nv * vz;
      quo = num / den;     // signed division truncates toward zero
      r   = az + quo;
      hi  = 192'sd2147483647;
      lo  = -192'sd2147483648;
      if (r > hi) r = hi;
      if (r < lo) r = lo;
      o.hit_status = thi_pkg::HitInside;
      o.result_z   = r[31:0];
    end
    return o;
  endfunction

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom_range(0, 4096) - 2048;
      1: return $urandom_range(0, 1 << 20) - (1 << 19);
      2: return $urandom;
      default: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
    endcase
  endfunction

  // Builds a triangle; the query is aimed inside most of the time.
  function automatic thi_pkg::in_item_t rand_item();
    thi_pkg::in_item_t it;
    int mode, kind;
    int wa, wb, sum;
    mode = $urandom_range(0, 9);
    mode = (mode < 5) ? 0 : (mode < 7) ? 1 : (mode < 9) ? 2 : 3;
    it = '0;
    it.corner_a_x = rand_coord(mode); it.corner_a_y = rand_coord(mode);
    it.corner_b_x = rand_coord(mode); it.corner_b_y = rand_coord(mode);
    it.corner_c_x = rand_coord(mode); it.corner_c_y = rand_coord(mode);
    it.corner_a_z = $urandom; it.corner_b_z = $urandom; it.corner_c_z = $urandom;
    if ($urandom_range(0, 3) == 0) begin
      it.corner_a_z = rand_coord(0); it.corner_b_z = rand_coord(0);
      it.corner_c_z = rand_coord(0);
    end
    it.query_z = $urandom;
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      wa = $urandom_range(0, 256);
      wb = $urandom_range(0, 256 - wa);
      sum = 256 - wa - wb;
      it.query_x = 32'((64'(signed'(it.corner_a_x)) * sum + 64'(signed'(it.corner_b_x)) * wa
                  + 64'(signed'(it.corner_c_x)) * wb) >>> 8);
      it.query_y = 32'((64'(signed'(it.corner_a_y)) * sum + 64'(signed'(it.corner_b_y)) * wa
                  + 64'(signed'(it.corner_c_y)) * wb) >>> 8);
    end else if (kind < 8) begin
      it.query_x = rand_coord(mode); it.query_y = rand_coord(mode);
    end else if (kind == 8) begin
      // collinear corners
      it.corner_c_x = it.corner_a_x + 2 * (it.corner_b_x - it.corner_a_x);
      it.corner_c_y = it.corner_a_y + 2 * (it.corner_b_y - it.corner_a_y);
      it.query_x = rand_coord(mode); it.query_y = rand_coord(mode);
    end else begin
      it.query_x = it.corner_b_x; it.query_y = it.corner_b_y;  // on a vertex
    end
    return it;
  endfunction

  function automatic thi_pkg::in_item_t tri_item(int ax, int ay, int bx, int by, int cx,
                                                 int cy, int qx, int qy, int az, int bz,
                                                 int cz, int qz);
    thi_pkg::in_item_t it;
    it.corner_a_x = ax; it.corner_a_y = ay; it.corner_a_z = az;
    it.corner_b_x = bx; it.corner_b_y = by; it.corner_b_z = bz;
    it.corner_c_x = cx; it.corner_c_y = cy; it.corner_c_z = cz;
    it.query_x = qx; it.query_y = qy; it.query_z = qz;
    return it;
  endfunction

  // Driver: one transaction per accepted start, changes at the falling edge.
  always @(negedge clk_i) begin
    int unsigned idle_pct;
    idle_pct = (phase == 0) ? 28 : (phase == 1) ? 49 : 0;
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || sent_last) begin
      if (sent_last) begin
        n_sent = n_sent + 1;
        void'(pending_q.pop_front());
      end
      if (pending_q.size() == 0 || (drain_req != 0 && height_q.size() != 0) ||
          $urandom_range(0, 99) < idle_pct) begin
        start <= 1'b0;
      end else begin
        drain_req = 0;
        start  <= 1'b1;
        item_i <= pending_q[0];
      end
    end
  end

  // Expectations enter at the accepting edge; results are checked the same way.
  always @(posedge clk_i) begin
    thi_pkg::out_item_t exp_o;
    sent_last = rst_ni && start && !busy;
    if (sent_last) begin
      exp_o = interp_height(item_i);
      height_q.insert(height_q.size(), exp_o);
      case (exp_o.hit_status)
        thi_pkg::HitInside:  n_inside++;
        thi_pkg::HitOutside: n_outside++;
        default:             n_degen++;
      endcase
    end
    if (rst_ni && valid_o) begin
      if (height_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", result_o);
      end else begin
        exp_o = height_q.pop_front();
        n_checked++;
        if (result_o.hit_status !== exp_o.hit_status || result_o.result_z !== exp_o.result_z)
        begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch #%0d: exp status %0d z %0d, got status %0d z %0d",
                     n_checked, exp_o.hit_status, exp_o.result_z,
                     result_o.hit_status, result_o.result_z);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MaxCycle) begin
      $display("timeout with %0d transactions outstanding", height_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic wait_sent();
    while (pending_q.size() != 0 || start) @(posedge clk_i);
  endtask

  initial begin
    int k;
    rst_ni = 1'b0; start = 1'b0; item_i = '0; sent_last = 1'b0;
    phase = 0; drain_req = 0; cycles = 0; mismatches = 0;
    n_inside = 0; n_outside = 0; n_degen = 0; n_sent = 0; n_checked = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // directed: interior, edge, vertex, outside, degenerate, extremes, saturation
    add_item(tri_item(0, 0, 2560, 0, 0, 2560, 256, 256, 0, 2560, 5120, 7));
    add_item(tri_item(0, 0, 2560, 0, 0, 2560, 1280, 1280, 100, 200, 300, 7));
    add_item(tri_item(0, 0, 2560, 0, 0, 2560, 0, 0, -9, 200, 300, 7));
    add_item(tri_item(0, 0, 2560, 0, 0, 2560, 2560, 2560, 1, 2, 3, -77));
    add_item(tri_item(0, 0, 2560, 0, 0, 2560, -1, 0, 1, 2, 3, 77));
    add_item(tri_item(0, 0, 256, 256, 512, 512, 256, 256, 1, 2, 3, 99));
    add_item(tri_item(5, 5, 5, 5, 5, 5, 5, 5, 1, 2, 3, -1));
    add_item(tri_item(0, 0, 2560, 0, 0, 2560, 0, 2560, 0, 0, -7, 0));
    add_item(tri_item(0, 0, 3, 0, 0, 3, 1, 1, 0, 1, -2, 0));
    add_item(tri_item(0, 0, 3, 0, 0, 3, 1, 1, 0, -1, 2, 0));
    add_item(tri_item(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
        32'h8000_0000, 32'h7fff_ffff, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
        32'h8000_0000));
    add_item(tri_item(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
        32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
        32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff));
    add_item(tri_item(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
        32'h7fff_ffff, 32'h8000_0000, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
        32'h7fff_ffff));
    add_item(tri_item(0, 0, 1, 0, 0, 1, 0, 0, 32'h7fff_ffff, 32'h8000_0000,
        32'h8000_0000, 0));
    add_item(tri_item(0, 0, 2, 0, 0, 2, 1, 0, 32'h7fff_ff00, 32'h7fff_ffff,
        32'h7fff_ffff, 0));
    add_item(tri_item(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
    add_item(tri_item(0, 0, 0, 2560, 2560, 0, 256, 256, 0, 2560, 5120, 7));
    wait_sent();

    // hold the sender once until every outstanding result is back
    for (k = 0; k < 280; k++) add_item(rand_item());
    drain_req = 1;
    wait_sent();
    phase = 1;
    for (k = 0; k < 280; k++) add_item(rand_item());
    wait_sent();
    phase = 2;
    for (k = 0; k < 290; k++) add_item(rand_item());
    wait_sent();

    while (height_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 5) @(posedge clk_i);

    $display("%0d transactions: %0d inside, %0d outside, %0d degenerate, %0d results",
             n_sent, n_inside, n_outside, n_degen, n_checked);
    $display("three sender idle profiles, drain hold, extreme coordinates, saturation");
    if (mismatches == 0 && height_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
